FILE: sv/srlf_pkg.sv
`timescale 1ns / 1ps
package srlf_pkg;

  localparam int ROWS_DEF       = 128;
  localparam int BORDER_COL_DEF = 160;
  localparam int ROW_STEP_DEF   = 4;

  localparam int ROW_W  = 7;
  localparam int COL_W  = 8;
  localparam int SLP_W  = 32;
  localparam int ICP_W  = 40;

  localparam logic [1:0] CFG_START_ROW = 2'd0;
  localparam logic [1:0] CFG_END_ROW   = 2'd1;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] column;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic signed [SLP_W-1:0] slope;
    logic signed [ICP_W-1:0] intercept;
    logic                    fit_valid;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_SUM_END,
    ST_MEAN,
    ST_DEV,
    ST_DEV_END,
    ST_DIV,
    ST_ICPT_MUL,
    ST_ICPT,
    ST_OUT
  } fit_state_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] dividend;
    logic        [63:0] divisor;
  } div_req_t;

endpackage

FILE: sv/srlf_div.sv
`timescale 1ns / 1ps
module srlf_div (
  input  logic             clk,
  input  logic             rst_n,
  input  srlf_pkg::div_req_t req,
  output logic             busy,
  output logic signed [63:0] quot
);
  import srlf_pkg::*;

  // Restoring division on magnitudes, one quotient bit per cycle; the
  // quotient is truncated toward zero.
  logic [63:0]  rem_r, rem_nxt;
  logic [63:0]  q_r, q_nxt;
  logic [63:0]  dvs_r, dvs_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic         neg_r, neg_nxt;
  logic         busy_r, busy_nxt;
  logic [64:0]  trial;
  logic [63:0]  shifted;

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    shifted  = {rem_r[62:0], q_r[63]};
    trial    = {1'b0, shifted} - {1'b0, dvs_r};
    if (req.start) begin
      rem_nxt  = '0;
      q_nxt    = req.dividend[63] ? 64'(-req.dividend) : 64'(req.dividend);
      dvs_nxt  = req.divisor;
      neg_nxt  = req.dividend[63];
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = {q_r[62:0], ~trial[64]};
      rem_nxt = trial[64] ? shifted : trial[63:0];
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign busy = busy_r;
  assign quot = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

FILE: sv/sampled_row_line_fit.sv
`timescale 1ns / 1ps
// Least-squares line fit over sampled rows of one frame.
// Input transactions (in_valid/in_stall) carry a row index, its boundary
// column and a last flag. Each column is written into a row store memory.
// Transactions without last are taken back to back while the block is idle.
// On a last transaction the block walks the configured row range every
// ROW_STEP rows from the higher row down, twice (sums, then deviations),
// one memory read per cycle; a serial divider gives the means between the
// walks and the slope after them. The time to the result is set by the two
// walks and the three divisions (shorter when no row is usable); in_stall is
// high meanwhile. One output transaction (out_valid/out_stall) follows each
// last transaction; the result is held while out_stall is high and the next
// input transaction is taken once the result is in the output register, but
// a last transaction waits while a held result is stalled. Configuration
// (cfg_we/cfg_index/cfg_data) is to be written by the user only while idle;
// the block does not enforce this. Reset (rst_n, synchronous) empties the
// output, sets start_row to 127, end_row to 0; the row store is not cleared.
module sampled_row_line_fit #(
  parameter int ROWS       = srlf_pkg::ROWS_DEF,
  parameter int BORDER_COL = srlf_pkg::BORDER_COL_DEF,
  parameter int ROW_STEP   = srlf_pkg::ROW_STEP_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  srlf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output srlf_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [6:0]          cfg_data
);
  import srlf_pkg::*;

  localparam int AW = $clog2(ROWS);
  localparam logic [COL_W-1:0] BCOL = COL_W'(BORDER_COL - 1);

  logic [COL_W-1:0] store [ROWS];
  logic [COL_W-1:0] rd_r;

  logic [6:0] start_r, end_r;
  fit_state_t st_r, st_nxt;
  logic signed [8:0] r_r, r_nxt;
  logic [7:0]  rrd_r, rrd_nxt;
  logic        rv_r, rv_nxt;
  logic [7:0]  n_r, n_nxt;
  logic [14:0] sx_r, sx_nxt;
  logic [15:0] sy_r, sy_nxt;
  logic [7:0]  mx_r, mx_nxt;
  logic [7:0]  my_r, my_nxt;
  logic signed [31:0] sxy_r, sxy_nxt;
  logic [31:0] sxx_r, sxx_nxt;
  logic signed [31:0] slope_r, slope_nxt;
  logic signed [41:0] prod_r, prod_nxt;
  logic [1:0]  dph_r, dph_nxt;
  out_item_t   ob_r, ob_nxt;
  logic        ov_r, ov_nxt;

  div_req_t    dreq;
  logic        dbusy;
  logic signed [63:0] dq;

  logic [6:0]  hi, lo;
  logic        acc_in, acc_out, used;
  logic signed [9:0] dx, dy;
  logic signed [63:0] sq;

  srlf_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .busy(dbusy), .quot(dq));

  assign hi = (start_r < end_r) ? end_r : start_r;
  assign lo = (start_r < end_r) ? start_r : end_r;
  assign acc_out = ov_r & ~out_stall;
  assign in_stall = (st_r != ST_IDLE) | (ov_r & out_stall & in_data.last);
  assign acc_in = in_valid & ~in_stall;
  assign used = rv_r & (rd_r != '0) & (rd_r != BCOL);
  assign dx = $signed({2'b0, rrd_r}) - $signed({2'b0, mx_r});
  assign dy = $signed({2'b0, rd_r}) - $signed({2'b0, my_r});

  always_ff @(posedge clk) begin
    if (acc_in && (32'(in_data.row_index) < ROWS)) begin
      store[AW'(in_data.row_index)] <= in_data.column;
    end
    rd_r <= store[AW'(r_r[7:0])];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:     if (acc_in && in_data.last) st_nxt = ST_SUM;
      ST_SUM:      if (r_r < $signed({2'b0, lo})) st_nxt = ST_SUM_END;
      ST_SUM_END:  st_nxt = ST_MEAN;
      ST_MEAN:     if (n_r == '0) st_nxt = ST_OUT;
                   else if (dph_r == 2'd2 && !dbusy) st_nxt = ST_DEV;
      ST_DEV:      if (r_r < $signed({2'b0, lo})) st_nxt = ST_DEV_END;
      ST_DEV_END:  st_nxt = (sxx_r == '0) ? ST_OUT : ST_DIV;
      ST_DIV:      if (dph_r == 2'd1 && !dbusy) st_nxt = ST_ICPT_MUL;
      ST_ICPT_MUL: st_nxt = ST_ICPT;
      ST_ICPT:     st_nxt = ST_OUT;
      ST_OUT:      if (!ov_r || acc_out) st_nxt = ST_IDLE;
      default:     st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    r_nxt = r_r; rrd_nxt = rrd_r; rv_nxt = 1'b0;
    n_nxt = n_r; sx_nxt = sx_r; sy_nxt = sy_r;
    mx_nxt = mx_r; my_nxt = my_r; sxy_nxt = sxy_r; sxx_nxt = sxx_r;
    slope_nxt = slope_r; prod_nxt = prod_r; dph_nxt = dph_r;
    ob_nxt = ob_r; ov_nxt = ov_r & ~acc_out;
    dreq = '{start: 1'b0, dividend: '0, divisor: '0};
    sq = 64'(sxy_r) * 64'sd65536;
    case (st_r)
      ST_IDLE: begin
        r_nxt = $signed({2'b0, hi});
        n_nxt = '0; sx_nxt = '0; sy_nxt = '0; sxy_nxt = '0; sxx_nxt = '0;
        dph_nxt = '0;
      end
      ST_SUM, ST_DEV: begin
        if (r_r >= $signed({2'b0, lo})) begin
          rv_nxt = (32'(r_r) < ROWS);
          rrd_nxt = r_r[7:0];
          r_nxt = r_r - 9'(ROW_STEP);
        end
      end
      ST_DIV: begin
        if (dph_r == 2'd0) begin
          dreq = '{start: 1'b1, dividend: sq, divisor: 64'(sxx_r)};
          dph_nxt = 2'd1;
        end else if (!dbusy) begin
          slope_nxt = (dq > 64'sd2147483647) ? 32'sh7fffffff :
                      (dq < -64'sd2147483648) ? 32'sh80000000 : dq[31:0];
        end
      end
      ST_ICPT_MUL: prod_nxt = 42'(slope_r) * $signed({34'b0, mx_r});
      ST_ICPT: begin
        ob_nxt.slope = slope_r;
        ob_nxt.intercept = 40'($signed({18'b0, my_r, 16'b0}) - prod_r);
        ob_nxt.fit_valid = 1'b1;
      end
      ST_MEAN: begin
        r_nxt = $signed({2'b0, hi});
        case (dph_r)
          2'd0: begin
            dreq = '{start: 1'b1, dividend: 64'(sx_r), divisor: 64'(n_r)};
            dph_nxt = 2'd1;
          end
          2'd1: if (!dbusy) begin
            mx_nxt = dq[7:0];
            dreq = '{start: 1'b1, dividend: 64'(sy_r), divisor: 64'(n_r)};
            dph_nxt = 2'd2;
          end
          default: if (!dbusy) begin
            my_nxt = dq[7:0];
            dph_nxt = '0;
          end
        endcase
        if (n_r == '0) ob_nxt = '0;
      end
      ST_DEV_END: if (sxx_r == '0) ob_nxt = '0;
      ST_OUT: if (!ov_r || acc_out) ov_nxt = 1'b1;
      default: ;
    endcase
    if ((st_r == ST_SUM || st_r == ST_SUM_END) && used) begin
      n_nxt = n_r + 8'd1;
      sx_nxt = sx_r + 15'(rrd_r);
      sy_nxt = sy_r + 16'(rd_r);
    end
    if ((st_r == ST_DEV || st_r == ST_DEV_END) && used) begin
      sxy_nxt = sxy_r + 32'(dx * dy);
      sxx_nxt = sxx_r + 32'(dx * dx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
      start_r <= 7'd127;
      end_r <= 7'd0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      if (cfg_we && cfg_index == CFG_START_ROW) start_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_END_ROW) end_r <= cfg_data;
    end
    r_r <= r_nxt; rrd_r <= rrd_nxt; rv_r <= rv_nxt;
    n_r <= n_nxt; sx_r <= sx_nxt; sy_r <= sy_nxt;
    mx_r <= mx_nxt; my_r <= my_nxt; sxy_r <= sxy_nxt; sxx_r <= sxx_nxt;
    slope_r <= slope_nxt; prod_r <= prod_nxt; dph_r <= dph_nxt;
    ob_r <= ob_nxt;
  end

  assign out_valid = ov_r;
  assign out_data = ob_r;

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> in_stall) else $error("input taken during fit");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> (ov_r && $stable(ob_r))) else $error("result lost");
  a_fit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !ob_r.fit_valid) |-> (ob_r.slope == '0 && ob_r.intercept == '0))
    else $error("invalid fit not zero");

endmodule
